### hw/rtl/asbb_pkg.sv
// Shared types, constants and strobe helpers for the AXI4 burst-to-beat bridge.
// Used by axi4_slave_burst_to_beat_bridge; depends on nothing else.
package asbb_pkg;

  // Data path is fixed at 64 bits, one memory access per beat.
  localparam int DATA_BYTES = 8;
  localparam int BYTE_OFF_W = 3;   // bits of a byte offset within a beat
  localparam int BYTES_W    = 4;   // holds 0..DATA_BYTES

  // Address step of an incrementing burst.
  localparam int BEAT_STEP = 8;

  // AXI burst type that increments; every other code keeps the address.
  localparam logic [1:0] BURST_INCR = 2'd1;

  // Memory command codes.
  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_READ  = 2'd1;
  localparam logic [1:0] MEM_WRITE = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_READ  = 2'd1,
    PH_WRITE = 2'd2
  } phase_t;

  // One result transaction as held in the output register.
  typedef struct packed {
    logic        addr_ready;
    logic        wdata_ready;
    logic        rd_valid;
    logic        rd_last;
    logic        rd_resp;
    logic [63:0] rd_data;
    logic        wr_resp_valid;
    logic        wr_resp;
    logic [1:0]  mem_cmd;
    logic [31:0] mem_addr;
    logic [BYTES_W-1:0] mem_bytes;
    logic [63:0] mem_wdata;
  } result_t;

  // Index of the lowest set strobe; 0 when no strobe is set.
  function automatic logic [BYTE_OFF_W-1:0] strobe_offset(input logic [DATA_BYTES-1:0] strb);
    logic [BYTE_OFF_W-1:0] off;
    off = '0;
    for (int i = DATA_BYTES - 1; i >= 0; i--) begin
      if (strb[i]) begin
        off = BYTE_OFF_W'(i);
      end
    end
    return off;
  endfunction

  // Length of the run of set bits starting at bit 0.
  function automatic logic [BYTES_W-1:0] strobe_run(input logic [DATA_BYTES-1:0] strb);
    logic [BYTES_W-1:0] n;
    logic               stop;
    n    = '0;
    stop = 1'b0;
    for (int i = 0; i < DATA_BYTES; i++) begin
      if (!stop && strb[i]) begin
        n = n + BYTES_W'(1);
      end else begin
        stop = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

### hw/rtl/axi4_slave_burst_to_beat_bridge.sv
// AXI4 slave front end: turns each read or write burst into one memory access per beat.
// Depends on asbb_pkg for types, codes and strobe helpers.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------------
//   input    | in_valid / in_stall  | address-channel offer, write beat, memory answer
//   output   | out_valid / out_stall| ready flags, read beat, write response, mem access
//
// Each input transaction is one bus cycle and yields exactly one result transaction.
// The result is computed by short logic from the burst state and the input, and lands
// in the output register at the accepting edge. One transaction per clock is sustained
// while the output side does not stall; in_stall rises only while the output register
// holds a result that the output side is stalling. Reset (rst, synchronous) returns the
// bridge to idle with all burst state and the pending write response cleared.
module axi4_slave_burst_to_beat_bridge #(
  parameter int ADDR_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        rd_addr_valid,
  input  logic        wr_addr_valid,
  input  logic [31:0] burst_addr,
  input  logic [7:0]  burst_len,
  input  logic [1:0]  burst_kind,
  input  logic [63:0] wdata,
  input  logic [7:0]  wstrb,
  input  logic [63:0] mem_rdata,
  input  logic        mem_fail,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        addr_ready,
  output logic        wdata_ready,
  output logic        rd_valid,
  output logic        rd_last,
  output logic        rd_resp,
  output logic [63:0] rd_data,
  output logic        wr_resp_valid,
  output logic        wr_resp,
  output logic [1:0]  mem_cmd,
  output logic [31:0] mem_addr,
  output logic [asbb_pkg::BYTES_W-1:0] mem_bytes,
  output logic [63:0] mem_wdata
);

  // Burst state.
  asbb_pkg::phase_t        phase, phase_next;
  logic [ADDR_WIDTH-1:0]   beat_addr, beat_addr_next;
  logic [7:0]              beats_left, beats_left_next;
  logic [1:0]              burst_mode, burst_mode_next;
  logic                    read_err_seen, read_err_seen_next;
  logic                    write_err_seen, write_err_seen_next;
  logic                    bresp_pending, bresp_pending_next;
  logic                    bresp_code, bresp_code_next;

  // Output register.
  asbb_pkg::result_t       res, res_next;
  asbb_pkg::result_t       res_reg;

  logic                    in_accept;
  logic [ADDR_WIDTH-1:0]   addr_step;
  logic [ADDR_WIDTH-1:0]   aligned_addr;
  logic [asbb_pkg::BYTE_OFF_W-1:0] wr_off;
  logic [asbb_pkg::BYTE_OFF_W-1:0] rd_off;

  // Hold off new transactions only while a finished result is being stalled.
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  // Fixed and wrap bursts keep the address; only incrementing bursts advance.
  assign addr_step    = (burst_mode == asbb_pkg::BURST_INCR) ?
                        ADDR_WIDTH'(asbb_pkg::BEAT_STEP) : '0;
  assign aligned_addr = {beat_addr[ADDR_WIDTH-1:asbb_pkg::BYTE_OFF_W],
                         {asbb_pkg::BYTE_OFF_W{1'b0}}};
  assign wr_off       = asbb_pkg::strobe_offset(wstrb);
  assign rd_off       = beat_addr[asbb_pkg::BYTE_OFF_W-1:0];

  always_comb begin
    phase_next          = phase;
    beat_addr_next      = beat_addr;
    beats_left_next     = beats_left;
    burst_mode_next     = burst_mode;
    read_err_seen_next  = read_err_seen;
    write_err_seen_next = write_err_seen;
    bresp_pending_next  = 1'b0;
    bresp_code_next     = 1'b0;

    res               = '0;
    // The write response registered on the previous last beat shows now.
    res.wr_resp_valid = bresp_pending;
    res.wr_resp       = bresp_pending && bresp_code;

    case (phase)
      asbb_pkg::PH_READ: begin
        res.rd_valid  = 1'b1;
        res.mem_cmd   = asbb_pkg::MEM_READ;
        res.mem_addr  = 32'(beat_addr);
        res.mem_bytes = asbb_pkg::BYTES_W'(asbb_pkg::DATA_BYTES);
        res.rd_data   = mem_rdata << {rd_off, 3'b000};
        res.rd_resp   = read_err_seen | mem_fail;
        if (beats_left == 8'd0) begin
          res.rd_last    = 1'b1;
          res.addr_ready = 1'b1;
        end else begin
          // Accumulate errors and advance to the next beat.
          read_err_seen_next = read_err_seen | mem_fail;
          beats_left_next    = beats_left - 8'd1;
          beat_addr_next     = beat_addr + addr_step;
        end
      end
      asbb_pkg::PH_WRITE: begin
        res.wdata_ready = 1'b1;
        res.mem_cmd     = asbb_pkg::MEM_WRITE;
        res.mem_addr    = 32'(aligned_addr + ADDR_WIDTH'(wr_off));
        res.mem_bytes   = asbb_pkg::strobe_run(wstrb >> wr_off);
        res.mem_wdata   = wdata >> {wr_off, 3'b000};
        if (beats_left == 8'd0) begin
          // Register the write response for the next result transaction.
          bresp_pending_next = 1'b1;
          bresp_code_next    = write_err_seen | mem_fail;
          res.addr_ready     = 1'b1;
        end else begin
          write_err_seen_next = write_err_seen | mem_fail;
          beats_left_next     = beats_left - 8'd1;
          beat_addr_next      = beat_addr + addr_step;
        end
      end
      default: begin
        res.addr_ready = 1'b1;
      end
    endcase

    // Take a new burst when ready; read wins over write.
    if (res.addr_ready) begin
      read_err_seen_next  = 1'b0;
      write_err_seen_next = 1'b0;
      if (rd_addr_valid) begin
        phase_next = asbb_pkg::PH_READ;
      end else if (wr_addr_valid) begin
        phase_next = asbb_pkg::PH_WRITE;
      end else begin
        phase_next = asbb_pkg::PH_IDLE;
      end
      if (rd_addr_valid || wr_addr_valid) begin
        beat_addr_next  = ADDR_WIDTH'(burst_addr);
        burst_mode_next = burst_kind;
        beats_left_next = burst_len;
      end
    end

    res_next = res;
  end

  // Advance burst state only on an accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= asbb_pkg::PH_IDLE;
      beat_addr      <= '0;
      beats_left     <= '0;
      burst_mode     <= '0;
      read_err_seen  <= 1'b0;
      write_err_seen <= 1'b0;
      bresp_pending  <= 1'b0;
      bresp_code     <= 1'b0;
    end else if (in_accept) begin
      phase          <= phase_next;
      beat_addr      <= beat_addr_next;
      beats_left     <= beats_left_next;
      burst_mode     <= burst_mode_next;
      read_err_seen  <= read_err_seen_next;
      write_err_seen <= write_err_seen_next;
      bresp_pending  <= bresp_pending_next;
      bresp_code     <= bresp_code_next;
    end
  end

  // Output register: load on accept, drop valid once taken with nothing new behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_reg <= res_next;
    end
  end

  assign addr_ready    = res_reg.addr_ready;
  assign wdata_ready   = res_reg.wdata_ready;
  assign rd_valid      = res_reg.rd_valid;
  assign rd_last       = res_reg.rd_last;
  assign rd_resp       = res_reg.rd_resp;
  assign rd_data       = res_reg.rd_data;
  assign wr_resp_valid = res_reg.wr_resp_valid;
  assign wr_resp       = res_reg.wr_resp;
  assign mem_cmd       = res_reg.mem_cmd;
  assign mem_addr      = res_reg.mem_addr;
  assign mem_bytes     = res_reg.mem_bytes;
  assign mem_wdata     = res_reg.mem_wdata;

endmodule

### test/bridge_check_pkg.sv
// Scoreboard for the AXI4 burst-to-beat bridge: per-transaction predictor and result checker.
// Depends on asbb_pkg for the result layout, phase codes and memory command codes.
package bridge_check_pkg;
  import asbb_pkg::*;

  // AXI burst type codes other than the incrementing one.
  localparam logic [1:0] BURST_FIXED = 2'd0;
  localparam logic [1:0] BURST_WRAP  = 2'd2;
  localparam logic [1:0] BURST_RSVD  = 2'd3;

  // One input transaction: one bus cycle seen by the bridge.
  typedef struct {
    logic        rd_addr_valid;
    logic        wr_addr_valid;
    logic [31:0] burst_addr;
    logic [7:0]  burst_len;
    logic [1:0]  burst_kind;
    logic [63:0] wdata;
    logic [7:0]  wstrb;
    logic [63:0] mem_rdata;
    logic        mem_fail;
  } bridge_beat_t;

  class beat_scoreboard;
    int      errors;
    result_t expected_results[$];

    phase_t      phase;
    logic [31:0] beat_addr;
    logic [7:0]  beats_left;
    logic [1:0]  burst_mode;
    logic        read_err;
    logic        write_err;
    logic        resp_pending;
    logic        resp_code;

    function new();
      errors       = 0;
      phase        = PH_IDLE;
      beat_addr    = '0;
      beats_left   = '0;
      burst_mode   = '0;
      read_err     = 1'b0;
      write_err    = 1'b0;
      resp_pending = 1'b0;
      resp_code    = 1'b0;
    endfunction

    // Lowest set strobe, 0 for an empty strobe.
    function logic [2:0] first_strobe(logic [7:0] strb);
      for (int i = 0; i < DATA_BYTES; i++) begin
        if (strb[i]) return 3'(i);
      end
      return 3'd0;
    endfunction

    // Count of ones from bit 0 up to the first zero.
    function logic [BYTES_W-1:0] low_run(logic [7:0] strb);
      int n;
      n = 0;
      while (n < DATA_BYTES && strb[n]) n++;
      return BYTES_W'(n);
    endfunction

    // True when the next transaction may start a burst.
    function bit will_take_burst();
      return phase == PH_IDLE || beats_left == 8'd0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Advance the predicted bridge by one accepted transaction.
    function void note_input(bridge_beat_t t);
      result_t     r;
      logic [31:0] stride;
      logic [2:0]  off;
      logic        take;
      logic        nxt_pend;
      logic        nxt_code;
      r        = '0;
      take     = 1'b0;
      nxt_pend = 1'b0;
      nxt_code = 1'b0;
      stride   = (burst_mode == BURST_INCR) ? 32'(BEAT_STEP) : 32'd0;
      r.wr_resp_valid = resp_pending;
      r.wr_resp       = resp_pending & resp_code;
      case (phase)
        PH_READ: begin
          r.rd_valid  = 1'b1;
          r.mem_cmd   = MEM_READ;
          r.mem_addr  = beat_addr;
          r.mem_bytes = BYTES_W'(DATA_BYTES);
          r.rd_data   = t.mem_rdata << (8 * beat_addr[2:0]);
          r.rd_resp   = read_err | t.mem_fail;
          if (beats_left == 8'd0) begin
            r.rd_last = 1'b1;
            take      = 1'b1;
          end else begin
            read_err   = read_err | t.mem_fail;
            beats_left = beats_left - 8'd1;
            beat_addr  = beat_addr + stride;
          end
        end
        PH_WRITE: begin
          off           = first_strobe(t.wstrb);
          r.wdata_ready = 1'b1;
          r.mem_cmd     = MEM_WRITE;
          r.mem_addr    = {beat_addr[31:3], 3'b000} + 32'(off);
          r.mem_bytes   = low_run(t.wstrb >> off);
          r.mem_wdata   = t.wdata >> (8 * off);
          if (beats_left == 8'd0) begin
            nxt_pend = 1'b1;
            nxt_code = write_err | t.mem_fail;
            take     = 1'b1;
          end else begin
            write_err  = write_err | t.mem_fail;
            beats_left = beats_left - 8'd1;
            beat_addr  = beat_addr + stride;
          end
        end
        default: begin
          take = 1'b1;
        end
      endcase
      if (take) begin
        read_err  = 1'b0;
        write_err = 1'b0;
        if (t.rd_addr_valid) phase = PH_READ;
        else if (t.wr_addr_valid) phase = PH_WRITE;
        else phase = PH_IDLE;
        if (t.rd_addr_valid || t.wr_addr_valid) begin
          beat_addr  = t.burst_addr;
          burst_mode = t.burst_kind;
          beats_left = t.burst_len;
        end
      end
      resp_pending = nxt_pend;
      resp_code    = nxt_code;
      r.addr_ready = take;
      expected_results.push_back(r);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t %s mismatch: expected %0h actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    // Check one result transaction against the oldest prediction.
    function void check_output(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result transaction: expected none actual %0h", $time, got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare("addr_ready", 64'(want.addr_ready), 64'(got.addr_ready));
      compare("wdata_ready", 64'(want.wdata_ready), 64'(got.wdata_ready));
      compare("rd_valid", 64'(want.rd_valid), 64'(got.rd_valid));
      compare("rd_last", 64'(want.rd_last), 64'(got.rd_last));
      compare("rd_resp", 64'(want.rd_resp), 64'(got.rd_resp));
      compare("rd_data", want.rd_data, got.rd_data);
      compare("wr_resp_valid", 64'(want.wr_resp_valid), 64'(got.wr_resp_valid));
      compare("wr_resp", 64'(want.wr_resp), 64'(got.wr_resp));
      compare("mem_cmd", 64'(want.mem_cmd), 64'(got.mem_cmd));
      compare("mem_addr", 64'(want.mem_addr), 64'(got.mem_addr));
      compare("mem_bytes", 64'(want.mem_bytes), 64'(got.mem_bytes));
      compare("mem_wdata", want.mem_wdata, got.mem_wdata);
    endfunction
  endclass

endpackage

### test/testbench.sv
// Top-level testbench for axi4_slave_burst_to_beat_bridge: directed and random bus cycles.
// Depends on asbb_pkg and bridge_check_pkg (scoreboard with the cycle predictor).
module testbench;
  import asbb_pkg::*;
  import bridge_check_pkg::*;

  // Cycles without any transaction on either side before the run is declared hung.
  localparam int HANG_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 436;

  logic clk;
  logic rst = 1'b1;

  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic        rd_addr_valid = 1'b0;
  logic        wr_addr_valid = 1'b0;
  logic [31:0] burst_addr    = '0;
  logic [7:0]  burst_len     = '0;
  logic [1:0]  burst_kind    = '0;
  logic [63:0] wdata         = '0;
  logic [7:0]  wstrb         = '0;
  logic [63:0] mem_rdata     = '0;
  logic        mem_fail      = 1'b0;

  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic        addr_ready;
  logic        wdata_ready;
  logic        rd_valid;
  logic        rd_last;
  logic        rd_resp;
  logic [63:0] rd_data;
  logic        wr_resp_valid;
  logic        wr_resp;
  logic [1:0]  mem_cmd;
  logic [31:0] mem_addr;
  logic [BYTES_W-1:0] mem_bytes;
  logic [63:0] mem_wdata;

  // Pack the output ports in the field order of result_t.
  result_t seen;
  assign seen = {addr_ready, wdata_ready, rd_valid, rd_last, rd_resp, rd_data,
                 wr_resp_valid, wr_resp, mem_cmd, mem_addr, mem_bytes, mem_wdata};

  beat_scoreboard sb;
  bit steady = 1'b0;     // suppress idling and stalls on both sides
  int idle_cycles = 0;

  axi4_slave_burst_to_beat_bridge dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rd_addr_valid (rd_addr_valid),
    .wr_addr_valid (wr_addr_valid),
    .burst_addr    (burst_addr),
    .burst_len     (burst_len),
    .burst_kind    (burst_kind),
    .wdata         (wdata),
    .wstrb         (wstrb),
    .mem_rdata     (mem_rdata),
    .mem_fail      (mem_fail),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .addr_ready    (addr_ready),
    .wdata_ready   (wdata_ready),
    .rd_valid      (rd_valid),
    .rd_last       (rd_last),
    .rd_resp       (rd_resp),
    .rd_data       (rd_data),
    .wr_resp_valid (wr_resp_valid),
    .wr_resp       (wr_resp),
    .mem_cmd       (mem_cmd),
    .mem_addr      (mem_addr),
    .mem_bytes     (mem_bytes),
    .mem_wdata     (mem_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stall the result side about one cycle in five, except in the steady stretch.
  always @(posedge clk) begin
    out_stall <= !rst && !steady && ($urandom_range(99) < 21);
  end

  // Check every accepted result transaction against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_output(seen);
    end
  end

  // Count cycles with no transaction on either side; end a hung run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic bit gap_now();
    return !steady && ($urandom_range(99) < 21);
  endfunction

  // Drive one bus cycle and hold it until accepted; optionally drain all
  // outstanding results first.
  task automatic push_cycle(input bridge_beat_t t, input bit drain);
    if (drain || gap_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ((drain && sb.pending() != 0) || gap_now()) @(posedge clk);
    end
    in_valid      <= 1'b1;
    rd_addr_valid <= t.rd_addr_valid;
    wr_addr_valid <= t.wr_addr_valid;
    burst_addr    <= t.burst_addr;
    burst_len     <= t.burst_len;
    burst_kind    <= t.burst_kind;
    wdata         <= t.wdata;
    wstrb         <= t.wstrb;
    mem_rdata     <= t.mem_rdata;
    mem_fail      <= t.mem_fail;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(t);
  endtask

  // Build a directed cycle; data drives the write beat and its inverse the memory answer.
  function automatic bridge_beat_t beat(bit rav, bit wav, logic [31:0] a, logic [7:0] len,
                                        logic [1:0] kind, logic [7:0] strb, bit fail,
                                        logic [63:0] data);
    bridge_beat_t t;
    t.rd_addr_valid = rav;
    t.wr_addr_valid = wav;
    t.burst_addr    = a;
    t.burst_len     = len;
    t.burst_kind    = kind;
    t.wdata         = data;
    t.wstrb         = strb;
    t.mem_rdata     = ~data;
    t.mem_fail      = fail;
    return t;
  endfunction

  // Random cycle: when a burst can start, mostly offer a well-formed burst with
  // short lengths; otherwise throw noise at the address channels.
  function automatic bridge_beat_t random_beat();
    bridge_beat_t t;
    int pick;
    int lo;
    int run;
    t.wdata     = {$urandom, $urandom};
    t.mem_rdata = {$urandom, $urandom};
    t.mem_fail  = ($urandom_range(99) < 10);
    if ($urandom_range(4) == 0) begin
      t.wstrb = 8'($urandom);
    end else begin
      lo      = $urandom_range(7);
      run     = $urandom_range(8 - lo);
      t.wstrb = 8'(((1 << run) - 1) << lo);
    end
    t.burst_addr = $urandom;
    if ($urandom_range(19) == 0) t.burst_addr[31:6] = '1;   // near the top: wrap
    t.burst_kind = ($urandom_range(1) == 1) ? BURST_INCR : 2'($urandom);
    if (sb.will_take_burst()) begin
      pick = $urandom_range(99);
      t.rd_addr_valid = (pick < 40) || (pick >= 75 && pick < 85);
      t.wr_addr_valid = (pick >= 40 && pick < 85);
      pick = $urandom_range(99);
      if (pick < 88) t.burst_len = 8'($urandom_range(7));
      else if (pick < 98) t.burst_len = 8'($urandom_range(31, 8));
      else t.burst_len = 8'($urandom);
    end else begin
      // Offers while a burst runs are ignored by the bridge.
      t.rd_addr_valid = ($urandom_range(4) == 0);
      t.wr_addr_valid = ($urandom_range(4) == 0);
      t.burst_len     = 8'($urandom);
    end
    return t;
  endfunction

  task automatic run_directed();
    // Idle cycle, then both channels offered at once: read wins, odd byte offset.
    push_cycle(beat(0, 0, 32'h0, 8'd0, BURST_FIXED, 8'h00, 0, '0), 0);
    push_cycle(beat(1, 1, 32'h0000_1003, 8'd1, BURST_INCR, 8'hFF, 0, '1), 0);
    // First read beat fails; the error must stick to the last beat.
    push_cycle(beat(0, 0, 32'h0, 8'd0, BURST_FIXED, 8'h00, 1, '0), 0);
    push_cycle(beat(0, 1, 32'h0000_2005, 8'd3, BURST_FIXED, 8'h00, 0,
                    64'h0123_4567_89AB_CDEF), 0);
    // Write beats: empty strobe, full strobe with error, gapped strobe, top byte.
    push_cycle(beat(0, 0, 32'h0, 8'd0, BURST_FIXED, 8'h00, 0, 64'hFEDC_BA98_7654_3210), 0);
    push_cycle(beat(0, 0, 32'h0, 8'd0, BURST_FIXED, 8'hFF, 1, '1), 0);
    push_cycle(beat(0, 0, 32'h0, 8'd0, BURST_FIXED, 8'h5A, 0, 64'hA5A5_5A5A_C3C3_3C3C), 0);
    // Last write beat; start a read that wraps past the top of the address space.
    push_cycle(beat(1, 0, 32'hFFFF_FFF8, 8'd2, BURST_INCR, 8'h80, 0,
                    64'h8000_0000_0000_0001), 0);
    push_cycle(beat(0, 0, 32'h0, 8'd0, BURST_FIXED, 8'h00, 0, 64'h5555_5555_5555_5555), 0);
    push_cycle(beat(0, 0, 32'h0, 8'd0, BURST_FIXED, 8'h00, 0, 64'hAAAA_AAAA_AAAA_AAAA), 0);
    // Single-beat write at the very last address with the reserved burst type.
    push_cycle(beat(0, 1, 32'hFFFF_FFFF, 8'd0, BURST_RSVD, 8'h00, 0, '0), 0);
    push_cycle(beat(1, 0, 32'h0000_0007, 8'd0, BURST_WRAP, 8'h0C, 1,
                    64'h1122_3344_5566_7788), 0);
    push_cycle(beat(0, 0, 32'h0, 8'd0, BURST_FIXED, 8'h00, 0, 64'h0F0F_0F0F_0F0F_0F0F), 0);
    // Longest burst: 256 write beats running across the address wrap.
    push_cycle(beat(0, 1, 32'hFFFF_FFF0, 8'd255, BURST_INCR, 8'hFF, 0, '0), 0);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      steady = (i >= 150 && i < 260);
      // Hold off the sender once until every result is back.
      push_cycle(random_beat(), i == 300);
    end
    steady = 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random(RANDOM_ITEMS);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/asbb_pkg.sv
hw/rtl/axi4_slave_burst_to_beat_bridge.sv
test/bridge_check_pkg.sv
test/testbench.sv
